FILE: design/owm_pkg.sv
// Package of the single-wire bus master: phase codes, command codes,
// register indexes and reset values, and the shared structure types.
// No dependencies.
package owm_pkg;

    localparam int REG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [REG_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_RESET_RELEASE = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_PRES_WAIT     = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_PRES_LOW      = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_SHORT_LOW     = 3'd4;
    localparam logic [REG_INDEX_W-1:0] REG_LONG_SLOT     = 3'd5;
    localparam logic [REG_INDEX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [REG_INDEX_W-1:0] REG_READ_TAIL     = 3'd7;

    localparam logic [9:0] RST_RESET_LOW     = 10'd750;
    localparam logic [7:0] RST_RESET_RELEASE = 8'd15;
    localparam logic [7:0] RST_PRES_WAIT     = 8'd200;
    localparam logic [7:0] RST_PRES_LOW      = 8'd240;
    localparam logic [5:0] RST_SHORT_LOW     = 6'd2;
    localparam logic [7:0] RST_LONG_SLOT     = 8'd60;
    localparam logic [5:0] RST_READ_SAMPLE   = 6'd12;
    localparam logic [7:0] RST_READ_TAIL     = 8'd50;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_RST_REL   = 4'd2;
    localparam logic [3:0] PH_PRES_HIGH = 4'd3;
    localparam logic [3:0] PH_PRES_LOW  = 4'd4;
    localparam logic [3:0] PH_W_LOW     = 4'd5;
    localparam logic [3:0] PH_W_REL     = 4'd6;
    localparam logic [3:0] PH_W_NEXT    = 4'd7;
    localparam logic [3:0] PH_R_LOW     = 4'd8;
    localparam logic [3:0] PH_R_WAIT    = 4'd9;
    localparam logic [3:0] PH_R_SAMPLE  = 4'd10;
    localparam logic [3:0] PH_R_TAIL    = 4'd11;
    localparam logic [3:0] PH_R_NEXT    = 4'd12;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] reset_release_time;
        logic [7:0] presence_wait_limit;
        logic [7:0] presence_low_limit;
        logic [5:0] short_low_time;
        logic [7:0] long_slot_time;
        logic [5:0] read_sample_time;
        logic [7:0] read_tail_time;
    } owm_cfg_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [9:0] timer;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic       error_flag;
        logic [7:0] last_read;
    } owm_state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] write_data;
        logic       line_level;
    } owm_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_error;
        logic [7:0] read_data;
    } owm_result_t;

endpackage

FILE: design/owm_ifs.sv
// Valid/ready channel interfaces of the single-wire bus master: the tick
// word going in and the status word coming out. No dependencies.
interface owm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] write_data;
    logic       line_level;

    modport source (output valid, command, write_data, line_level, input ready);
    modport sink (input valid, command, write_data, line_level, output ready);
endinterface

interface owm_rsp_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_error;
    logic [7:0] read_data;

    modport source (output valid, drive_low, busy_res, done_res, presence_error, read_data,
                    input ready);
    modport sink (input valid, drive_low, busy_res, done_res, presence_error, read_data,
                  output ready);
endinterface

FILE: design/owm_cfg_regs.sv
// Timing register file of the single-wire bus master, written through a
// plain write port. Depends on owm_pkg.
module owm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [owm_pkg::REG_INDEX_W-1:0]  cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output owm_pkg::owm_cfg_t                cfg
);
    import owm_pkg::*;

    owm_cfg_t cfg_reg;
    owm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RESET_LOW:     cfg_next.reset_low_time      = cfg_data;
                REG_RESET_RELEASE: cfg_next.reset_release_time  = cfg_data[7:0];
                REG_PRES_WAIT:     cfg_next.presence_wait_limit = cfg_data[7:0];
                REG_PRES_LOW:      cfg_next.presence_low_limit  = cfg_data[7:0];
                REG_SHORT_LOW:     cfg_next.short_low_time      = cfg_data[5:0];
                REG_LONG_SLOT:     cfg_next.long_slot_time      = cfg_data[7:0];
                REG_READ_SAMPLE:   cfg_next.read_sample_time    = cfg_data[5:0];
                REG_READ_TAIL:     cfg_next.read_tail_time      = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time      <= RST_RESET_LOW;
            cfg_reg.reset_release_time  <= RST_RESET_RELEASE;
            cfg_reg.presence_wait_limit <= RST_PRES_WAIT;
            cfg_reg.presence_low_limit  <= RST_PRES_LOW;
            cfg_reg.short_low_time      <= RST_SHORT_LOW;
            cfg_reg.long_slot_time      <= RST_LONG_SLOT;
            cfg_reg.read_sample_time    <= RST_READ_SAMPLE;
            cfg_reg.read_tail_time      <= RST_READ_TAIL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/owm_step.sv
// Next-state logic of the single-wire bus master for one microsecond tick:
// command start, phase timing, presence check and bit slots. Depends on owm_pkg.
module owm_step (
    input  owm_pkg::owm_cfg_t    cfg,
    input  owm_pkg::owm_state_t  cur,
    input  owm_pkg::owm_item_t   item,
    output owm_pkg::owm_state_t  nxt,
    output owm_pkg::owm_result_t res
);
    import owm_pkg::*;

    typedef struct packed {
        owm_state_t st;
        logic       done;
    } ent_t;

    // Enters a phase, skipping phases whose duration is zero.
    function automatic ent_t enter_phase(input logic [3:0] p, input owm_state_t s,
                                         input owm_cfg_t c);
        ent_t       r;
        logic [3:0] q;
        logic       one;
        logic [7:0] dl;
        logic [7:0] dr;
        logic [3:0] bc;
        r.st   = s;
        r.done = 1'b0;
        q      = p;
        one    = s.shift_byte[0];
        dr     = one ? c.long_slot_time : {2'b00, c.short_low_time};
        if (q == PH_W_REL && dr == 8'd0)
            q = PH_W_NEXT;
        if (q == PH_R_TAIL && c.read_tail_time <= 8'd1)
            q = PH_R_NEXT;
        bc = 4'(s.bit_count + 4'd1);
        if (q == PH_W_NEXT)
        begin
            r.st.shift_byte = {1'b0, s.shift_byte[7:1]};
            r.st.bit_count  = bc;
            q = (bc >= 4'd8) ? PH_IDLE : PH_W_LOW;
        end
        else if (q == PH_R_NEXT)
        begin
            r.st.bit_count = bc;
            if (bc >= 4'd8)
            begin
                r.st.last_read = s.shift_byte;
                q = PH_IDLE;
            end
            else
            begin
                q = PH_R_LOW;
            end
        end
        one = r.st.shift_byte[0];
        dl  = one ? {2'b00, c.short_low_time} : c.long_slot_time;
        dr  = one ? c.long_slot_time : {2'b00, c.short_low_time};
        unique case (q)
            PH_RST_LOW, PH_RST_REL:
            begin
                if (q == PH_RST_LOW && c.reset_low_time != 10'd0)
                begin
                    r.st.phase = PH_RST_LOW;
                    r.st.timer = c.reset_low_time;
                end
                else if (c.reset_release_time != 8'd0)
                begin
                    r.st.phase = PH_RST_REL;
                    r.st.timer = {2'b00, c.reset_release_time};
                end
                else
                begin
                    r.st.phase = PH_PRES_HIGH;
                    r.st.timer = 10'd0;
                end
            end
            PH_PRES_HIGH:
            begin
                r.st.phase = PH_PRES_HIGH;
                r.st.timer = 10'd0;
            end
            PH_W_LOW:
            begin
                if (dl != 8'd0)
                begin
                    r.st.phase = PH_W_LOW;
                    r.st.timer = {2'b00, dl};
                end
                else if (dr != 8'd0)
                begin
                    r.st.phase = PH_W_REL;
                    r.st.timer = {2'b00, dr};
                end
                else
                begin
                    r.st.phase = PH_IDLE;
                    r.st.timer = 10'd0;
                    r.done     = 1'b1;
                end
            end
            PH_W_REL:
            begin
                r.st.phase = PH_W_REL;
                r.st.timer = {2'b00, dr};
            end
            PH_R_LOW, PH_R_WAIT:
            begin
                if (q == PH_R_LOW && c.short_low_time != 6'd0)
                begin
                    r.st.phase = PH_R_LOW;
                    r.st.timer = {4'd0, c.short_low_time};
                end
                else if (c.read_sample_time != 6'd0)
                begin
                    r.st.phase = PH_R_WAIT;
                    r.st.timer = {4'd0, c.read_sample_time};
                end
                else
                begin
                    r.st.phase = PH_R_SAMPLE;
                    r.st.timer = 10'd1;
                end
            end
            PH_R_SAMPLE:
            begin
                r.st.phase = PH_R_SAMPLE;
                r.st.timer = 10'd1;
            end
            PH_R_TAIL:
            begin
                r.st.phase = PH_R_TAIL;
                r.st.timer = {2'b00, 8'(c.read_tail_time - 8'd1)};
            end
            default:
            begin
                r.st.phase = PH_IDLE;
                r.st.timer = 10'd0;
                r.done     = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic logic [3:0] successor(input logic [3:0] p);
        logic [3:0] q;
        unique case (p)
            PH_RST_LOW:  q = PH_RST_REL;
            PH_RST_REL:  q = PH_PRES_HIGH;
            PH_W_LOW:    q = PH_W_REL;
            PH_W_REL:    q = PH_W_NEXT;
            PH_R_LOW:    q = PH_R_WAIT;
            PH_R_WAIT:   q = PH_R_SAMPLE;
            PH_R_SAMPLE: q = PH_R_TAIL;
            PH_R_TAIL:   q = PH_R_NEXT;
            default:     q = PH_IDLE;
        endcase
        return q;
    endfunction

    ent_t       start_ent;
    ent_t       tick_ent;
    owm_state_t s;
    logic       done;
    logic       drive;
    logic [9:0] count_up;
    logic [9:0] count_down;
    logic [3:0] start_phase;

    always_comb
    begin
        s           = cur;
        done        = 1'b0;
        drive       = 1'b0;
        start_phase = PH_R_LOW;
        if (item.command == CMD_RESET)
            start_phase = PH_RST_LOW;
        else if (item.command == CMD_WRITE)
            start_phase = PH_W_LOW;

        if (cur.phase == PH_IDLE && item.command != CMD_NONE)
        begin
            s.bit_count = 4'd0;
            case (item.command)
                CMD_RESET: s.error_flag = 1'b0;
                CMD_WRITE: s.shift_byte = item.write_data;
                default:   s.shift_byte = 8'd0;
            endcase
        end
        start_ent = enter_phase(start_phase, s, cfg);
        if (cur.phase == PH_IDLE && item.command != CMD_NONE)
        begin
            s    = start_ent.st;
            done = start_ent.done;
        end

        count_up   = 10'(s.timer + 10'd1);
        count_down = (s.timer != 10'd0) ? 10'(s.timer - 10'd1) : 10'd0;
        tick_ent   = '0;

        case (s.phase)
            PH_IDLE:
            begin
                s = s;
            end
            PH_PRES_HIGH:
            begin
                if (item.line_level)
                begin
                    s.timer = count_up;
                    if (count_up >= {2'b00, cfg.presence_wait_limit})
                    begin
                        s.error_flag = 1'b1;
                        s.phase      = PH_IDLE;
                        s.timer      = 10'd0;
                        done         = 1'b1;
                    end
                end
                else
                begin
                    s.phase = PH_PRES_LOW;
                    s.timer = 10'd1;
                    if (cfg.presence_low_limit <= 8'd1)
                    begin
                        s.error_flag = 1'b1;
                        s.phase      = PH_IDLE;
                        s.timer      = 10'd0;
                        done         = 1'b1;
                    end
                end
            end
            PH_PRES_LOW:
            begin
                if (!item.line_level)
                begin
                    s.timer = count_up;
                    if (count_up >= {2'b00, cfg.presence_low_limit})
                    begin
                        s.error_flag = 1'b1;
                        s.phase      = PH_IDLE;
                        s.timer      = 10'd0;
                        done         = 1'b1;
                    end
                end
                else
                begin
                    s.phase = PH_IDLE;
                    s.timer = 10'd0;
                    done    = 1'b1;
                end
            end
            default:
            begin
                drive = (s.phase == PH_RST_LOW) || (s.phase == PH_W_LOW)
                        || (s.phase == PH_R_LOW);
                if (s.phase == PH_R_SAMPLE)
                    s.shift_byte = {item.line_level, s.shift_byte[7:1]};
                s.timer  = count_down;
                tick_ent = enter_phase(successor(s.phase), s, cfg);
                if (count_down == 10'd0)
                begin
                    s    = tick_ent.st;
                    done = done | tick_ent.done;
                end
            end
        endcase

        nxt                = s;
        res.drive_low      = drive;
        res.busy_res       = (s.phase != PH_IDLE);
        res.done_res       = done;
        res.presence_error = s.error_flag;
        res.read_data      = s.last_read;
    end

endmodule

FILE: design/one_wire_bus_master.sv
// Single-wire bus master. Each input word is one microsecond tick carrying the
// sampled line level and an optional command (reset with presence check, write
// byte, read byte; commands are taken only while idle), and each tick yields
// exactly one status word with the drive level, busy, done, presence error and
// the last read byte. One word is accepted every clock cycle unless the status
// side stalls; a word's status becomes valid once it has passed the input
// register and then the result register, and both sides may stall freely. The
// timing registers are written through the plain write port and should be
// changed only while idle.
// Depends on owm_pkg, owm_ifs, owm_cfg_regs and owm_step.
module one_wire_bus_master (
    input  logic                             clk,
    input  logic                             rst_n,
    owm_req_if.sink                          req,
    owm_rsp_if.source                        rsp,
    input  logic                             cfg_wr_en,
    input  logic [owm_pkg::REG_INDEX_W-1:0]  cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import owm_pkg::*;

    owm_cfg_t    cfg;
    owm_item_t   item_reg;
    logic        in_valid_reg;
    owm_state_t  state_reg;
    owm_state_t  state_next;
    owm_result_t step_res;
    owm_result_t res_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        req_fire;

    owm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owm_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg.command    <= req.command;
            item_reg.write_data <= req.write_data;
            item_reg.line_level <= req.line_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_IDLE;
            state_reg.timer      <= 10'd0;
            state_reg.bit_count  <= 4'd0;
            state_reg.shift_byte <= 8'd0;
            state_reg.error_flag <= 1'b0;
            state_reg.last_read  <= 8'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= step_res;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.drive_low      = res_reg.drive_low;
    assign rsp.busy_res       = res_reg.busy_res;
    assign rsp.done_res       = res_reg.done_res;
    assign rsp.presence_error = res_reg.presence_error;
    assign rsp.read_data      = res_reg.read_data;

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without a word being processed");

    a_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("buffered input word dropped while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done reported while still busy");

    a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != PH_IDLE && state_reg.phase != PH_PRES_HIGH
         && state_reg.phase != PH_PRES_LOW) |-> state_reg.timer != 10'd0)
        else $error("timed phase holds an expired timer");

endmodule
